[rtl/core/rgbd_pc_pkg.sv]
// ============================================================================
// rgbd_pc_pkg
// Shared types, widths and constants for the RGB-D point cloud block.
// ============================================================================
package rgbd_pc_pkg;

    // Frame limits
    localparam int MAX_WIDTH      = 4096;
    localparam int MAX_HEIGHT     = 4096;
    localparam int MAX_DECIMATION = 16;

    // Field widths
    localparam int SIZE_W   = 13;                   // image size registers
    localparam int COL_W    = $clog2(MAX_WIDTH);    // column counters
    localparam int ROW_W    = $clog2(MAX_HEIGHT);   // row counters
    localparam int PHASE_W  = 4;
    localparam int DEC_W    = 5;
    localparam int COORD_W  = 16;                   // Q12.4 camera constants
    localparam int DEPTH_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int INDEX_W  = 24;
    localparam int POINT_W  = 32;

    // Config port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Reciprocal table for size / decimation
    localparam int RECIP_SHIFT = SIZE_W + 4;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Projection datapath
    localparam int DIFF_W     = COORD_W + 2;        // signed pos*16 - center
    localparam int PROD_W     = COORD_W + DEPTH_W;  // |diff| * depth
    localparam int DIVD_W     = PROD_W + 6;         // 2*16*prod + focal
    localparam int DIVS_W     = COORD_W + 1;        // 2*focal
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Reset values of the registers
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam int RST_DECIMATION   = 1;
    localparam int RST_CENTER_X     = 5120;
    localparam int RST_CENTER_Y     = 3840;
    localparam int RST_FOCAL_X      = 8400;
    localparam int RST_FOCAL_Y      = 8400;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_DECIMATION   = 3'd2,
        REG_CENTER_X     = 3'd3,
        REG_CENTER_Y     = 3'd4,
        REG_FOCAL_X      = 3'd5,
        REG_FOCAL_Y      = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_LAUNCH,
        BK_DIV
    } t_back_state;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_mm;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_pixel;

    typedef struct packed {
        logic signed [POINT_W-1:0] point_x;
        logic signed [POINT_W-1:0] point_y;
        logic [DEPTH_W-1:0]        point_z;
        logic [COLOR_W-1:0]        out_blue;
        logic [COLOR_W-1:0]        out_green;
        logic [COLOR_W-1:0]        out_red;
        logic [INDEX_W-1:0]        point_index;
        logic                      last_point;
    } t_point;

    // Kept pixel handed from front to back
    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [DEPTH_W-1:0] depth_mm;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
        logic [INDEX_W-1:0] point_index;
        logic               last_point;
    } t_job;

    // Camera constants; focal values already forced nonzero
    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] focal_x;
        logic [COORD_W-1:0] focal_y;
    } t_proj_cfg;

    // ceil(2^RECIP_SHIFT / d); floor(v * recip >> RECIP_SHIFT) == v / d for
    // every size value in range.
    function automatic logic [RECIP_W-1:0] recip(input logic [DEC_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            5'd1:    r = RECIP_W'((2**RECIP_SHIFT) / 1);
            5'd2:    r = RECIP_W'(((2**RECIP_SHIFT) + 1) / 2);
            5'd3:    r = RECIP_W'(((2**RECIP_SHIFT) + 2) / 3);
            5'd4:    r = RECIP_W'(((2**RECIP_SHIFT) + 3) / 4);
            5'd5:    r = RECIP_W'(((2**RECIP_SHIFT) + 4) / 5);
            5'd6:    r = RECIP_W'(((2**RECIP_SHIFT) + 5) / 6);
            5'd7:    r = RECIP_W'(((2**RECIP_SHIFT) + 6) / 7);
            5'd8:    r = RECIP_W'(((2**RECIP_SHIFT) + 7) / 8);
            5'd9:    r = RECIP_W'(((2**RECIP_SHIFT) + 8) / 9);
            5'd10:   r = RECIP_W'(((2**RECIP_SHIFT) + 9) / 10);
            5'd11:   r = RECIP_W'(((2**RECIP_SHIFT) + 10) / 11);
            5'd12:   r = RECIP_W'(((2**RECIP_SHIFT) + 11) / 12);
            5'd13:   r = RECIP_W'(((2**RECIP_SHIFT) + 12) / 13);
            5'd14:   r = RECIP_W'(((2**RECIP_SHIFT) + 13) / 14);
            5'd15:   r = RECIP_W'(((2**RECIP_SHIFT) + 14) / 15);
            5'd16:   r = RECIP_W'(((2**RECIP_SHIFT) + 15) / 16);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/rgbd_pc_front.sv]
// ============================================================================
// rgbd_pc_front
// Config registers, raster position tracking and decimation filter.
// ============================================================================
module rgbd_pc_front import rgbd_pc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  t_pixel                 i_in_word,
    input  logic                   i_q_full,
    output logic                   o_push,
    output t_job                   o_job,
    output t_proj_cfg              o_proj_cfg
);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // size / decimation by reciprocal multiply
    function automatic logic [SIZE_W-1:0] cloud_size(input logic [SIZE_W-1:0] v,
                                                     input logic [DEC_W-1:0] d);
        logic [SIZE_W+RECIP_W-1:0] p;
        p = v * recip(d);
        return p[RECIP_SHIFT +: SIZE_W];
    endfunction

    function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] p,
                                                      input logic [DEC_W-1:0] d);
        logic [DEC_W-1:0] p1;
        p1 = DEC_W'(p) + DEC_W'(1);
        return (p1 >= d) ? '0 : PHASE_W'(p1);
    endfunction

    // config (stored as effective values) and derived cloud size
    logic [SIZE_W-1:0]  r_width,  n_width;
    logic [SIZE_W-1:0]  r_height, n_height;
    logic [DEC_W-1:0]   r_dec,    n_dec;
    logic [SIZE_W-1:0]  r_ow,     n_ow;
    logic [SIZE_W-1:0]  r_oh,     n_oh;
    t_proj_cfg          r_proj,   n_proj;

    // raster position
    logic [COL_W-1:0]   r_col,       n_col;
    logic [ROW_W-1:0]   r_row,       n_row;
    logic [PHASE_W-1:0] r_col_phase, n_col_phase;
    logic [PHASE_W-1:0] r_row_phase, n_row_phase;
    logic [COL_W-1:0]   r_out_col,   n_out_col;
    logic [ROW_W-1:0]   r_out_row,   n_out_row;

    logic                      accept;
    logic                      keep;
    logic [ROW_W+SIZE_W-1:0]   row_base;

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_dec    = r_dec;
        n_proj   = r_proj;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  n_width  = clamp_size(i_cfg_data[SIZE_W-1:0],
                                                        SIZE_W'(MAX_WIDTH));
                REG_IMAGE_HEIGHT: n_height = clamp_size(i_cfg_data[SIZE_W-1:0],
                                                        SIZE_W'(MAX_HEIGHT));
                REG_DECIMATION: begin
                    n_dec = (i_cfg_data[DEC_W-1:0] > DEC_W'(MAX_DECIMATION)) ?
                            DEC_W'(MAX_DECIMATION) : i_cfg_data[DEC_W-1:0];
                end
                REG_CENTER_X:     n_proj.center_x = i_cfg_data;
                REG_CENTER_Y:     n_proj.center_y = i_cfg_data;
                REG_FOCAL_X: begin
                    n_proj.focal_x = (i_cfg_data == '0) ? COORD_W'(1) : i_cfg_data;
                end
                REG_FOCAL_Y: begin
                    n_proj.focal_y = (i_cfg_data == '0) ? COORD_W'(1) : i_cfg_data;
                end
                default: ;
            endcase
        end
        n_ow = cloud_size(n_width, n_dec);
        n_oh = cloud_size(n_height, n_dec);
    end

    assign accept = i_in_valid && !i_q_full;

    assign keep = (r_dec != '0) && (r_col_phase == '0) && (r_row_phase == '0) &&
                  (SIZE_W'(r_out_col) < r_ow) && (SIZE_W'(r_out_row) < r_oh);

    assign row_base = r_out_row * r_ow;

    always_comb begin
        o_job.col         = r_col;
        o_job.row         = r_row;
        o_job.depth_mm    = i_in_word.depth_mm;
        o_job.blue        = i_in_word.blue;
        o_job.green       = i_in_word.green;
        o_job.red         = i_in_word.red;
        o_job.point_index = INDEX_W'(row_base) + INDEX_W'(r_out_col);
        o_job.last_point  = (SIZE_W'(r_out_col) + SIZE_W'(1) == r_ow) &&
                            (SIZE_W'(r_out_row) + SIZE_W'(1) == r_oh);
    end

    assign o_push     = accept && keep;
    assign o_proj_cfg = r_proj;

    always_comb begin
        n_col       = r_col;
        n_row       = r_row;
        n_col_phase = r_col_phase;
        n_row_phase = r_row_phase;
        n_out_col   = r_out_col;
        n_out_row   = r_out_row;
        if (accept) begin
            if (SIZE_W'(r_col) + SIZE_W'(1) >= r_width) begin
                n_col       = '0;
                n_col_phase = '0;
                n_out_col   = '0;
                if (SIZE_W'(r_row) + SIZE_W'(1) >= r_height) begin
                    n_row       = '0;
                    n_row_phase = '0;
                    n_out_row   = '0;
                end else begin
                    n_row = r_row + ROW_W'(1);
                    if (r_dec != '0 && r_row_phase == '0) begin
                        n_out_row = r_out_row + ROW_W'(1);
                    end
                    n_row_phase = next_phase(r_row_phase, r_dec);
                end
            end else begin
                n_col = r_col + COL_W'(1);
                if (r_dec != '0 && r_col_phase == '0) begin
                    n_out_col = r_out_col + COL_W'(1);
                end
                n_col_phase = next_phase(r_col_phase, r_dec);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width         <= SIZE_W'(RST_IMAGE_WIDTH);
            r_height        <= SIZE_W'(RST_IMAGE_HEIGHT);
            r_dec           <= DEC_W'(RST_DECIMATION);
            r_ow            <= SIZE_W'(RST_IMAGE_WIDTH / RST_DECIMATION);
            r_oh            <= SIZE_W'(RST_IMAGE_HEIGHT / RST_DECIMATION);
            r_proj.center_x <= COORD_W'(RST_CENTER_X);
            r_proj.center_y <= COORD_W'(RST_CENTER_Y);
            r_proj.focal_x  <= COORD_W'(RST_FOCAL_X);
            r_proj.focal_y  <= COORD_W'(RST_FOCAL_Y);
            r_col           <= '0;
            r_row           <= '0;
            r_col_phase     <= '0;
            r_row_phase     <= '0;
            r_out_col       <= '0;
            r_out_row       <= '0;
        end else begin
            r_width     <= n_width;
            r_height    <= n_height;
            r_dec       <= n_dec;
            r_ow        <= n_ow;
            r_oh        <= n_oh;
            r_proj      <= n_proj;
            r_col       <= n_col;
            r_row       <= n_row;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
            r_out_col   <= n_out_col;
            r_out_row   <= n_out_row;
        end
    end

endmodule

[rtl/core/rgbd_pc_queue.sv]
// ============================================================================
// rgbd_pc_queue
// Short FIFO of kept pixels between the front and the back.
// ============================================================================
module rgbd_pc_queue import rgbd_pc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count,  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[rtl/core/rgbd_pc_div.sv]
// ============================================================================
// rgbd_pc_div
// Restoring divider, one quotient bit per cycle; result held until restart.
// ============================================================================
module rgbd_pc_div import rgbd_pc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVS_W-1:0]    r_rem, n_rem;
    logic [DIVD_W-1:0]    r_quo, n_quo;
    logic [DIVS_W-1:0]    r_dvs;

    logic [DIVS_W:0]      trial;
    logic [DIVS_W:0]      trial_sub;
    logic                 ge;

    always_comb begin
        trial     = {r_rem, r_quo[DIVD_W-1]};
        trial_sub = trial - {1'b0, r_dvs};
        ge        = (trial >= {1'b0, r_dvs});
        n_rem     = ge ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
        n_quo     = {r_quo[DIVD_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DIVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/core/rgbd_pc_back.sv]
// ============================================================================
// rgbd_pc_back
// Back-projection of one kept pixel at a time, with the output register.
// ============================================================================
module rgbd_pc_back import rgbd_pc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_job      i_head,
    input  t_proj_cfg i_proj_cfg,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_point    o_out_word
);

    localparam logic [DIVD_W-1:0] NEG_LIMIT = DIVD_W'(64'h0000_0000_8000_0000);
    localparam logic [DIVD_W-1:0] POS_LIMIT = DIVD_W'(64'h0000_0000_7FFF_FFFF);

    function automatic logic [COORD_W-1:0] magnitude(input logic [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] neg_d;
        neg_d = DIFF_W'(0) - d;
        return d[DIFF_W-1] ? neg_d[COORD_W-1:0] : d[COORD_W-1:0];
    endfunction

    function automatic logic [POINT_W-1:0] saturate(input logic [DIVD_W-1:0] q,
                                                    input logic neg);
        logic [DIVD_W-1:0] neg_q;
        logic [POINT_W-1:0] r;
        neg_q = DIVD_W'(0) - q;
        if (neg) begin
            r = (q > NEG_LIMIT) ? 32'h8000_0000 : neg_q[POINT_W-1:0];
        end else begin
            r = (q > POS_LIMIT) ? 32'h7FFF_FFFF : q[POINT_W-1:0];
        end
        return r;
    endfunction

    t_back_state r_state, n_state;
    t_job        r_job;
    logic [PROD_W-1:0] r_prod_x, r_prod_y;
    logic        r_neg_x, r_neg_y;
    logic        r_out_valid;
    t_point      r_out_word;

    logic [DIFF_W-1:0] diff_x, diff_y;
    logic [PROD_W-1:0] prod_x, prod_y;
    logic [DIVD_W-1:0] dividend_x, dividend_y;
    logic [DIVS_W-1:0] divisor_x, divisor_y;
    logic [DIVD_W-1:0] quo_x, quo_y;
    logic              done_x, done_y;
    logic              out_free;
    logic              start;
    logic              load_out;

    // signed (pos * 16 - center), then |.| * depth
    assign diff_x = DIFF_W'({r_job.col, 4'b0000}) - DIFF_W'(i_proj_cfg.center_x);
    assign diff_y = DIFF_W'({r_job.row, 4'b0000}) - DIFF_W'(i_proj_cfg.center_y);
    assign prod_x = magnitude(diff_x) * r_job.depth_mm;
    assign prod_y = magnitude(diff_y) * r_job.depth_mm;

    // round to nearest: (2*16*prod + f) / (2*f)
    assign dividend_x = DIVD_W'({r_prod_x, 5'b00000}) + DIVD_W'(i_proj_cfg.focal_x);
    assign dividend_y = DIVD_W'({r_prod_y, 5'b00000}) + DIVD_W'(i_proj_cfg.focal_y);
    assign divisor_x  = {i_proj_cfg.focal_x, 1'b0};
    assign divisor_y  = {i_proj_cfg.focal_y, 1'b0};

    rgbd_pc_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (dividend_x),
        .i_divisor  (divisor_x),
        .o_done     (done_x),
        .o_quotient (quo_x)
    );

    rgbd_pc_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (dividend_y),
        .i_divisor  (divisor_y),
        .o_done     (done_y),
        .o_quotient (quo_y)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:   if (!i_q_empty) n_state = BK_MUL;
            BK_MUL:    n_state = BK_LAUNCH;
            BK_LAUNCH: n_state = BK_DIV;
            BK_DIV:    if (done_x && done_y && out_free) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop    = 1'b0;
        start    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            BK_IDLE:   o_pop = !i_q_empty;
            BK_MUL:    ;
            BK_LAUNCH: start = 1'b1;
            BK_DIV:    load_out = done_x && done_y && out_free;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (r_state == BK_MUL) begin
            r_prod_x <= prod_x;
            r_prod_y <= prod_y;
            r_neg_x  <= diff_x[DIFF_W-1];
            r_neg_y  <= diff_y[DIFF_W-1];
        end
        if (load_out) begin
            r_out_word.point_x     <= saturate(quo_x, r_neg_x);
            r_out_word.point_y     <= saturate(quo_y, r_neg_y);
            r_out_word.point_z     <= r_job.depth_mm;
            r_out_word.out_blue    <= r_job.blue;
            r_out_word.out_green   <= r_job.green;
            r_out_word.out_red     <= r_job.red;
            r_out_word.point_index <= r_job.point_index;
            r_out_word.last_point  <= r_job.last_point;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[rtl/core/rgbd_pixel_to_point_cloud.sv]
// ============================================================================
// rgbd_pixel_to_point_cloud
// Pinhole back-projection of a raster RGB-D pixel stream into a point cloud.
// ============================================================================
// Throughput: one input word per cycle while the queue has room and pixels
//   are dropped by decimation; the back end takes one kept pixel at a time,
//   and each one waits on the 38-step bit-serial dividers (38 quotient bits
//   of the rounded x and y quotients).
// Reset (i_rst_n low, synchronous): registers take their default values,
//   raster position returns to the frame origin, queue and output empty.
// ============================================================================
module rgbd_pixel_to_point_cloud import rgbd_pc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // pixel words in
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  t_pixel                 i_in_word,
    // point words out
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output t_point                 o_out_word
);

    // Front: owns the config registers and the raster counters. It takes
    // a word whenever the queue has room, drops pixels that are off the
    // decimation grid or cropped, and pushes kept pixels together with
    // their point index and last-of-frame flag.
    //
    // Queue: four entries, so a run of dropped pixels keeps flowing while
    // the back end is busy with a point.
    //
    // Back: multiplies |pos*16 - center| by depth, then divides by the
    // focal length with rounding on two parallel serial dividers (x, y),
    // saturates to 32 bits and parks the point in the output register.

    logic      q_full;
    logic      q_empty;
    logic      push;
    logic      pop;
    t_job      front_job;
    t_job      head_job;
    t_proj_cfg proj_cfg;

    rgbd_pc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (front_job),
        .o_proj_cfg  (proj_cfg)
    );

    rgbd_pc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rgbd_pc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head_job),
        .i_proj_cfg  (proj_cfg),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Input stalls only when the queue is full; this never depends on valid.
    assign o_in_stall = q_full;

endmodule
